// File: hw/rtl/ppu_rmp_pkg.sv
// ----------------------------------------------------------------------------
// ppu_rmp_pkg
// Shared codes and address map of the video chip's CPU register port.
// ----------------------------------------------------------------------------
package ppu_rmp_pkg;

  // Bus item codes
  typedef enum logic [2:0] {
    OP_REG_READ  = 3'd0,
    OP_REG_WRITE = 3'd1,
    OP_PAT_LOAD  = 3'd2,
    OP_OAM_WRITE = 3'd3,
    OP_VBL_BEGIN = 3'd4,
    OP_VBL_END   = 3'd5
  } op_e;

  // CPU visible register numbers
  typedef enum logic [2:0] {
    REG_CTRL     = 3'd0,
    REG_MASK     = 3'd1,
    REG_STATUS   = 3'd2,
    REG_OAM_ADDR = 3'd3,
    REG_OAM_DATA = 3'd4,
    REG_SCROLL   = 3'd5,
    REG_VADDR    = 3'd6,
    REG_VDATA    = 3'd7
  } reg_e;

  // Configuration register indexes
  localparam logic CFG_MIRROR_MODE      = 1'b0;
  localparam logic CFG_PATTERN_WRITABLE = 1'b1;

  // Source of the byte returned by an item
  typedef enum logic [1:0] {
    SRC_VALUE   = 2'd0,
    SRC_PATTERN = 2'd1,
    SRC_NAME    = 2'd2
  } src_e;

  localparam int unsigned LOAD_ADDR_W = 13;
  localparam int unsigned OAM_BYTES   = 256;
  localparam int unsigned OAM_AW      = $clog2(OAM_BYTES);
  localparam int unsigned TABLE_BYTES = 1024;
  localparam int unsigned NAME_AW     = $clog2(TABLE_BYTES);
  localparam int unsigned NAME_LANES  = 4;
  localparam int unsigned PAL_ENTRIES = 32;
  localparam int unsigned PAL_AW      = $clog2(PAL_ENTRIES);

  // Video address map
  localparam logic [15:0] VA_PATTERN_END = 16'h1FFF;
  localparam logic [15:0] VA_NAME_END    = 16'h2FFF;
  localparam logic [15:0] VA_PAL_BASE    = 16'h3F00;
  localparam logic [15:0] VA_PAL_END     = 16'h3F1F;
  localparam logic [15:0] VA_STEP_WIDE   = 16'd32;
  localparam logic [15:0] VA_STEP_ONE    = 16'd1;

endpackage

// File: hw/rtl/ppu_register_memory_port.sv
// ----------------------------------------------------------------------------
// ppu_register_memory_port
// Pipeline: the RAM read stage (s1), then the result register (out). An
//   accepted beat is registered in each before its result beat is valid.
// Throughput: one beat per cycle when not stalled by the result or the sweep;
//   single-port, registered-read pattern and name RAMs, one entry per item.
// Reset: async, active low. Registers and palette clear at once; name-table
//   RAM is then swept to zero row by row, input held off meanwhile.
// ----------------------------------------------------------------------------
module ppu_register_memory_port #(
  parameter int unsigned PATTERN_BYTES = 8192
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [0:0]  cfg_data_i,
  // input beat
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  opcode_i,
  input  logic [2:0]  reg_index_i,
  input  logic [12:0] load_address_i,
  input  logic [7:0]  data_i,
  // result beat
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  read_data_o,
  output logic        nmi_o
);

  localparam int unsigned PAT_AW = $clog2(PATTERN_BYTES);
  localparam int unsigned NAME_AW = ppu_rmp_pkg::NAME_AW;
  localparam int unsigned NLANES = ppu_rmp_pkg::NAME_LANES;
  localparam int unsigned PAL_AW = ppu_rmp_pkg::PAL_AW;
  // one bit above the load address so the limit itself fits
  localparam logic [ppu_rmp_pkg::LOAD_ADDR_W:0] PAT_LIMIT =
    (ppu_rmp_pkg::LOAD_ADDR_W + 1)'(PATTERN_BYTES);

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  logic mirror_mode_q, pattern_writable_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mirror_mode_q      <= 1'b0;
      pattern_writable_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ppu_rmp_pkg::CFG_MIRROR_MODE:      mirror_mode_q      <= cfg_data_i[0];
        ppu_rmp_pkg::CFG_PATTERN_WRITABLE: pattern_writable_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Architectural registers
  // --------------------------------------------------------------------------
  logic [7:0]  ctrl_q, ctrl_d;
  logic [7:0]  mask_q, mask_d;
  logic [7:0]  status_q, status_d;
  logic [ppu_rmp_pkg::OAM_AW-1:0] oam_ptr_q, oam_ptr_d;
  logic        latch_q, latch_d;
  logic [7:0]  first_byte_q, first_byte_d;
  logic [15:0] va_q, va_d;

  // Name-table clear sweep after reset
  logic [NAME_AW:0] clr_cnt_q;
  logic             clearing;
  assign clearing = ~clr_cnt_q[NAME_AW];

  // Pipeline: s1 waits on the RAM read, out is the result register
  logic                s1_valid_q;
  ppu_rmp_pkg::src_e   s1_src_q, s1_src_d;
  logic [1:0]          s1_lane_q, s1_lane_d;
  logic [7:0]          s1_value_q, s1_value_d;
  logic                s1_nmi_q, s1_nmi_d;
  logic                s1_adv;
  logic                out_valid_q;
  logic [7:0]          out_rd_q;
  logic                out_nmi_q;
  logic                acc;

  assign s1_adv     = ~out_valid_q | out_ready_i;
  assign in_ready_o = ~clearing & (~s1_valid_q | s1_adv);
  assign acc        = in_valid_i & in_ready_o;

  // --------------------------------------------------------------------------
  // Video address decode
  // --------------------------------------------------------------------------
  logic is_pat, is_name, is_pal;
  logic [PAL_AW-1:0] pal_idx;
  logic [1:0]        name_tbl;
  logic [15:0]       va_step;

  assign is_pat   = (va_q <= ppu_rmp_pkg::VA_PATTERN_END);
  assign is_name  = ~is_pat & (va_q <= ppu_rmp_pkg::VA_NAME_END);
  assign is_pal   = (va_q >= ppu_rmp_pkg::VA_PAL_BASE) & (va_q <= ppu_rmp_pkg::VA_PAL_END);
  assign pal_idx  = va_q[PAL_AW-1:0];
  assign name_tbl = va_q[NAME_AW+1:NAME_AW];
  assign va_step  = va_q + (ctrl_q[2] ? ppu_rmp_pkg::VA_STEP_WIDE : ppu_rmp_pkg::VA_STEP_ONE);

  // Pattern index: source is below twice the depth, so one conditional subtract
  ppu_rmp_pkg::op_e op;
  ppu_rmp_pkg::reg_e ridx;
  logic [ppu_rmp_pkg::LOAD_ADDR_W-1:0] pat_src;
  logic [ppu_rmp_pkg::LOAD_ADDR_W:0]   pat_ext, pat_mod;
  logic [PAT_AW-1:0]                   pat_addr;

  assign op       = ppu_rmp_pkg::op_e'(opcode_i);
  assign ridx     = ppu_rmp_pkg::reg_e'(reg_index_i);
  assign pat_src  = (op == ppu_rmp_pkg::OP_PAT_LOAD) ? load_address_i
                                                     : va_q[ppu_rmp_pkg::LOAD_ADDR_W-1:0];
  assign pat_ext  = {1'b0, pat_src};
  assign pat_mod  = (pat_ext >= PAT_LIMIT) ? (pat_ext - PAT_LIMIT) : pat_ext;
  assign pat_addr = pat_mod[PAT_AW-1:0];

  // Name-table mirror: each write lands in the two tables that share it
  logic [NLANES-1:0] name_pair;
  always_comb begin
    if (!mirror_mode_q) begin
      name_pair = name_tbl[1] ? 4'b1100 : 4'b0011;
    end else begin
      name_pair = name_tbl[0] ? 4'b1010 : 4'b0101;
    end
  end

  // Palette storage (small, kept in flops)
  logic [7:0]             pal_q [ppu_rmp_pkg::PAL_ENTRIES];
  logic [ppu_rmp_pkg::PAL_ENTRIES-1:0] pal_we;

  // --------------------------------------------------------------------------
  // Item decode and register update
  // --------------------------------------------------------------------------
  logic              pat_we, pat_re, name_re;
  logic [NLANES-1:0] name_be;

  always_comb begin
    ctrl_d       = ctrl_q;
    mask_d       = mask_q;
    status_d     = status_q;
    oam_ptr_d    = oam_ptr_q;
    latch_d      = latch_q;
    first_byte_d = first_byte_q;
    va_d         = va_q;
    pat_we       = 1'b0;
    pat_re       = 1'b0;
    name_re      = 1'b0;
    name_be      = '0;
    pal_we       = '0;
    s1_src_d     = ppu_rmp_pkg::SRC_VALUE;
    s1_lane_d    = name_tbl;
    s1_value_d   = 8'h00;
    s1_nmi_d     = 1'b0;

    if (acc) begin
      unique case (op)
        ppu_rmp_pkg::OP_REG_READ: begin
          unique case (ridx)
            ppu_rmp_pkg::REG_CTRL: s1_value_d = ctrl_q;
            ppu_rmp_pkg::REG_MASK: s1_value_d = mask_q;
            ppu_rmp_pkg::REG_STATUS: begin
              s1_value_d  = status_q;
              status_d[7] = 1'b0;
              latch_d     = 1'b0;
            end
            ppu_rmp_pkg::REG_VDATA: begin
              va_d = va_step;
              if (is_pat) begin
                s1_src_d = ppu_rmp_pkg::SRC_PATTERN;
                pat_re   = 1'b1;
              end else if (is_name) begin
                s1_src_d = ppu_rmp_pkg::SRC_NAME;
                name_re  = 1'b1;
              end else if (is_pal) begin
                s1_value_d = pal_q[pal_idx];
              end
            end
            default: s1_value_d = 8'h00;
          endcase
        end
        ppu_rmp_pkg::OP_REG_WRITE: begin
          // all writes but the status register load status bits 4..0
          if (ridx != ppu_rmp_pkg::REG_STATUS) begin
            status_d[4:0] = data_i[4:0];
          end
          unique case (ridx)
            ppu_rmp_pkg::REG_CTRL:     ctrl_d = data_i;
            ppu_rmp_pkg::REG_MASK:     mask_d = data_i;
            ppu_rmp_pkg::REG_STATUS:   ;
            ppu_rmp_pkg::REG_OAM_ADDR: oam_ptr_d = data_i;
            // sprite bytes have no read path here, only the pointer moves
            ppu_rmp_pkg::REG_OAM_DATA: oam_ptr_d = oam_ptr_q + 8'd1;
            ppu_rmp_pkg::REG_SCROLL:   latch_d = ~latch_q;
            ppu_rmp_pkg::REG_VADDR: begin
              if (!latch_q) begin
                first_byte_d = data_i;
                latch_d      = 1'b1;
              end else begin
                va_d         = {first_byte_q, data_i};
                first_byte_d = 8'h00;
                latch_d      = 1'b0;
              end
            end
            ppu_rmp_pkg::REG_VDATA: begin
              va_d = va_step;
              if (is_pat) begin
                pat_we = pattern_writable_q;
              end else if (is_name) begin
                name_be = name_pair;
              end else if (is_pal) begin
                // backdrop entries are shared between the two halves
                if (pal_idx[1:0] == 2'b00) begin
                  pal_we[{1'b0, pal_idx[PAL_AW-2:0]}] = 1'b1;
                  pal_we[{1'b1, pal_idx[PAL_AW-2:0]}] = 1'b1;
                end else begin
                  pal_we[pal_idx] = 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
        ppu_rmp_pkg::OP_PAT_LOAD:  pat_we = 1'b1;
        ppu_rmp_pkg::OP_OAM_WRITE: ;
        ppu_rmp_pkg::OP_VBL_BEGIN: begin
          status_d[7] = 1'b1;
          s1_nmi_d    = ctrl_q[7];
        end
        ppu_rmp_pkg::OP_VBL_END:   status_d[7] = 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q       <= '0;
      mask_q       <= '0;
      status_q     <= '0;
      oam_ptr_q    <= '0;
      latch_q      <= 1'b0;
      first_byte_q <= '0;
      va_q         <= '0;
      clr_cnt_q    <= '0;
    end else begin
      ctrl_q       <= ctrl_d;
      mask_q       <= mask_d;
      status_q     <= status_d;
      oam_ptr_q    <= oam_ptr_d;
      latch_q      <= latch_d;
      first_byte_q <= first_byte_d;
      va_q         <= va_d;
      if (clearing) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
    end
  end

  // Palette flops, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ppu_rmp_pkg::PAL_ENTRIES; i++) begin
        pal_q[i] <= 8'h00;
      end
    end else begin
      for (int i = 0; i < ppu_rmp_pkg::PAL_ENTRIES; i++) begin
        if (pal_we[i]) begin
          pal_q[i] <= data_i;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Pattern RAM: single port, registered read, contents undefined after reset
  // --------------------------------------------------------------------------
  logic [7:0] pat_mem [PATTERN_BYTES];
  logic [7:0] pat_rdata_q;

  always_ff @(posedge clk_i) begin
    if (pat_we) begin
      pat_mem[pat_addr] <= data_i;
    end
    if (pat_re) begin
      pat_rdata_q <= pat_mem[pat_addr];
    end
  end

  // --------------------------------------------------------------------------
  // Name-table RAM: one row per offset, one byte lane per table, so a mirrored
  // write is a single row write with two lanes enabled.
  // --------------------------------------------------------------------------
  logic [NLANES-1:0][7:0] name_mem [ppu_rmp_pkg::TABLE_BYTES];
  logic [NLANES-1:0][7:0] name_rdata_q;
  logic [NAME_AW-1:0]     nm_row;
  logic [NLANES-1:0]      nm_be;
  logic [7:0]             nm_wdata;

  assign nm_row   = clearing ? clr_cnt_q[NAME_AW-1:0] : va_q[NAME_AW-1:0];
  assign nm_be    = clearing ? {NLANES{1'b1}} : name_be;
  assign nm_wdata = clearing ? 8'h00 : data_i;

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < NLANES; l++) begin
      if (nm_be[l]) begin
        name_mem[nm_row][l] <= nm_wdata;
      end
    end
    if (name_re) begin
      name_rdata_q <= name_mem[va_q[NAME_AW-1:0]];
    end
  end

  // --------------------------------------------------------------------------
  // Result path. RAM read data holds while s1 stalls: reads only start on
  // an accepted beat, and none is accepted then.
  // --------------------------------------------------------------------------
  logic [7:0] s1_rd;
  always_comb begin
    unique case (s1_src_q)
      ppu_rmp_pkg::SRC_PATTERN: s1_rd = pat_rdata_q;
      ppu_rmp_pkg::SRC_NAME:    s1_rd = name_rdata_q[s1_lane_q];
      default:                  s1_rd = s1_value_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= acc | (s1_valid_q & ~s1_adv);
      out_valid_q <= (s1_valid_q & s1_adv) | (out_valid_q & ~out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_src_q   <= s1_src_d;
      s1_lane_q  <= s1_lane_d;
      s1_value_q <= s1_value_d;
      s1_nmi_q   <= s1_nmi_d;
    end
    if (s1_valid_q && s1_adv) begin
      out_rd_q  <= s1_rd;
      out_nmi_q <= s1_nmi_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = out_rd_q;
  assign nmi_o       = out_nmi_q;

endmodule

// File: hw/rtl/ppu_rmp_checker.sv
// ----------------------------------------------------------------------------
// ppu_rmp_checker
// Port-level checks on the register port, bound into each instance of it.
// ----------------------------------------------------------------------------
module ppu_rmp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  read_data_o,
  input logic        nmi_o
);

  // beats accepted but not yet delivered
  logic [1:0] pend_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i & in_ready_o;
  assign out_acc = out_valid_o & out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_data_o) && $stable(nmi_o))
    else $error("result beat changed while stalled");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 2'd0)
    else $error("result beat without an accepted input beat");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("more than two beats in flight");

  a_nmi_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && nmi_o |-> read_data_o == 8'h00)
    else $error("nmi beat carries read data");

endmodule

bind ppu_register_memory_port ppu_rmp_checker u_ppu_rmp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .read_data_o (read_data_o),
  .nmi_o       (nmi_o)
);

// File: test/ppu_register_memory_port_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ppu_register_memory_port_tb
// Self-checking bench for the video chip's CPU register port. A queue of bus
// beats feeds a valid/ready driver; an in-order shadow of the register file
// and video memories predicts each reply, which the monitor checks field by
// field. Random gaps on both sides, one long receiver hold-off, and all four
// mirror / pattern-write settings.
// ----------------------------------------------------------------------------
module ppu_register_memory_port_tb;

  localparam int unsigned PAT_BYTES    = 8192;
  localparam int unsigned HOLD_CYCLES  = 400;   // long receiver hold-off
  localparam int unsigned STALL_LIMIT  = 6000;  // covers the clear sweep and hold
  localparam int unsigned PHASE_BEATS  = 270;
  localparam int unsigned MAX_REPORTS  = 10;

  // Opcodes with no meaning; the block must answer them with zeros
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [2:0]  op;
    logic [2:0]  idx;
    logic [12:0] la;
    logic [7:0]  d;
  } cpu_beat_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       nmi;
  } cpu_reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [0:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready_o;
  logic [2:0]  opcode = '0;
  logic [2:0]  reg_index = '0;
  logic [12:0] load_address = '0;
  logic [7:0]  wdata = '0;
  logic        out_valid_o;
  logic        out_ready = 1'b0;
  logic [7:0]  read_data_o;
  logic        nmi_o;

  ppu_register_memory_port #(
    .PATTERN_BYTES(PAT_BYTES)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode),
    .reg_index_i   (reg_index),
    .load_address_i(load_address),
    .data_i        (wdata),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready),
    .read_data_o   (read_data_o),
    .nmi_o         (nmi_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Shadow state of the port: registers, latch and the three video memories.
  // Pattern bytes carry a 'known' flag so reads of unwritten entries are
  // never issued.
  // --------------------------------------------------------------------------
  bit        sh_mirror;
  bit        sh_pat_wr;
  bit [7:0]  sh_ctrl;
  bit [7:0]  sh_mask;
  bit [7:0]  sh_status;
  bit [7:0]  sh_oam_ptr;
  bit [7:0]  sh_oam [ppu_rmp_pkg::OAM_BYTES];
  bit        sh_latch;
  bit [7:0]  sh_hi_byte;
  bit [15:0] sh_vaddr;
  bit [7:0]  sh_pat [PAT_BYTES];
  bit        sh_pat_known [PAT_BYTES];
  bit [7:0]  sh_name [ppu_rmp_pkg::NAME_LANES * ppu_rmp_pkg::TABLE_BYTES];
  bit [7:0]  sh_pal [ppu_rmp_pkg::PAL_ENTRIES];

  cpu_beat_t  cpu_beats_q [$];   // beats waiting for the driver
  cpu_reply_t reply_q [$];       // replies owed by the block, oldest first

  int unsigned beats_queued   = 0;
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles    = 0;
  bit          gaps_on  = 1'b1;
  bit          hold_req = 1'b0;
  logic        in_taken = 1'b0;

  function automatic void advance_vaddr();
    sh_vaddr = sh_vaddr + (sh_ctrl[2] ? ppu_rmp_pkg::VA_STEP_WIDE : ppu_rmp_pkg::VA_STEP_ONE);
  endfunction

  // Reply to one bus beat, updating the shadow state as the port would
  function automatic cpu_reply_t cpu_access_reply(cpu_beat_t b);
    cpu_reply_t res;
    logic [1:0] tbl;
    logic [1:0] t0;
    logic [1:0] t1;
    logic [4:0] p;
    res = '0;
    case (b.op)
      ppu_rmp_pkg::OP_REG_READ: begin
        case (b.idx)
          ppu_rmp_pkg::REG_CTRL: res.rdata = sh_ctrl;
          ppu_rmp_pkg::REG_MASK: res.rdata = sh_mask;
          ppu_rmp_pkg::REG_STATUS: begin
            res.rdata = sh_status;
            sh_status[7] = 1'b0;
            sh_latch = 1'b0;
          end
          ppu_rmp_pkg::REG_VDATA: begin
            if (sh_vaddr <= ppu_rmp_pkg::VA_PATTERN_END) begin
              res.rdata = sh_pat[sh_vaddr[12:0]];
            end else if (sh_vaddr <= ppu_rmp_pkg::VA_NAME_END) begin
              res.rdata = sh_name[sh_vaddr[11:0]];
            end else if (sh_vaddr >= ppu_rmp_pkg::VA_PAL_BASE &&
                         sh_vaddr <= ppu_rmp_pkg::VA_PAL_END) begin
              res.rdata = sh_pal[sh_vaddr[4:0]];
            end
            advance_vaddr();
          end
          default: res.rdata = 8'h00;
        endcase
      end
      ppu_rmp_pkg::OP_REG_WRITE: begin
        case (b.idx)
          ppu_rmp_pkg::REG_CTRL:     sh_ctrl = b.d;
          ppu_rmp_pkg::REG_MASK:     sh_mask = b.d;
          ppu_rmp_pkg::REG_OAM_ADDR: sh_oam_ptr = b.d;
          ppu_rmp_pkg::REG_OAM_DATA: begin
            sh_oam[sh_oam_ptr] = b.d;
            sh_oam_ptr = sh_oam_ptr + 8'd1;
          end
          ppu_rmp_pkg::REG_SCROLL: sh_latch = ~sh_latch;
          ppu_rmp_pkg::REG_VADDR: begin
            if (!sh_latch) begin
              sh_hi_byte = b.d;
              sh_latch = 1'b1;
            end else begin
              sh_vaddr = {sh_hi_byte, b.d};
              sh_hi_byte = 8'h00;
              sh_latch = 1'b0;
            end
          end
          ppu_rmp_pkg::REG_VDATA: begin
            if (sh_vaddr <= ppu_rmp_pkg::VA_PATTERN_END) begin
              if (sh_pat_wr) begin
                sh_pat[sh_vaddr[12:0]] = b.d;
                sh_pat_known[sh_vaddr[12:0]] = 1'b1;
              end
            end else if (sh_vaddr <= ppu_rmp_pkg::VA_NAME_END) begin
              // both tables of the mirrored pair take the byte
              tbl = sh_vaddr[11:10];
              if (!sh_mirror) begin
                t0 = {tbl[1], 1'b0};
                t1 = {tbl[1], 1'b1};
              end else begin
                t0 = {1'b0, tbl[0]};
                t1 = {1'b1, tbl[0]};
              end
              sh_name[{t0, sh_vaddr[9:0]}] = b.d;
              sh_name[{t1, sh_vaddr[9:0]}] = b.d;
            end else if (sh_vaddr >= ppu_rmp_pkg::VA_PAL_BASE &&
                         sh_vaddr <= ppu_rmp_pkg::VA_PAL_END) begin
              p = sh_vaddr[4:0];
              if (p[1:0] == 2'b00) begin
                // backdrop entries are shared between the two halves
                sh_pal[{1'b0, p[3:0]}] = b.d;
                sh_pal[{1'b1, p[3:0]}] = b.d;
              end else begin
                sh_pal[p] = b.d;
              end
            end
            advance_vaddr();
          end
          default: ;
        endcase
        if (b.idx != ppu_rmp_pkg::REG_STATUS) sh_status[4:0] = b.d[4:0];
      end
      ppu_rmp_pkg::OP_PAT_LOAD: begin
        sh_pat[b.la] = b.d;
        sh_pat_known[b.la] = 1'b1;
      end
      ppu_rmp_pkg::OP_OAM_WRITE: sh_oam[b.la[7:0]] = b.d;
      ppu_rmp_pkg::OP_VBL_BEGIN: begin
        sh_status[7] = 1'b1;
        res.nmi = sh_ctrl[7];
      end
      ppu_rmp_pkg::OP_VBL_END: sh_status[7] = 1'b0;
      default: ;
    endcase
    return res;
  endfunction

  // Queue one beat and its reply. A data-port read that would land on a
  // pattern byte never written is turned into a load of that byte.
  task automatic push_beat(logic [2:0] op, logic [2:0] idx, logic [12:0] la, logic [7:0] d);
    cpu_beat_t b;
    if (op == ppu_rmp_pkg::OP_REG_READ && idx == ppu_rmp_pkg::REG_VDATA &&
        sh_vaddr <= ppu_rmp_pkg::VA_PATTERN_END && !sh_pat_known[sh_vaddr[12:0]]) begin
      op = ppu_rmp_pkg::OP_PAT_LOAD;
      la = sh_vaddr[12:0];
    end
    b.op  = op;
    b.idx = idx;
    b.la  = la;
    b.d   = d;
    reply_q.push_back(cpu_access_reply(b));
    cpu_beats_q.push_back(b);
    if (op <= ppu_rmp_pkg::OP_VBL_END) beats_queued++;
  endtask

  task automatic pick_vaddr(output logic [15:0] va);
    case ($urandom_range(0, 9))
      0, 1, 2: va = 16'($urandom_range(0, 16'h1FFF));
      3, 4, 5: va = 16'($urandom_range(16'h2000, 16'h2FFF));
      6, 7:    va = 16'($urandom_range(16'h3F00, 16'h3F1F));
      8:       va = $urandom_range(0, 1) ? 16'($urandom_range(16'h3000, 16'h3EFF))
                                         : 16'($urandom_range(16'h3F20, 16'hFFFF));
      default: begin
        case ($urandom_range(0, 7))
          0: va = 16'h1FFF;
          1: va = 16'h2000;
          2: va = 16'h2FFF;
          3: va = 16'h3000;
          4: va = 16'h3EFF;
          5: va = 16'h3F1F;
          6: va = 16'h3F20;
          default: va = 16'hFFFF;
        endcase
      end
    endcase
  endtask

  // One short bus sequence, mostly well formed, sometimes plain noise
  task automatic random_burst();
    int unsigned sel;
    int unsigned n;
    logic [15:0] va;
    logic [15:0] step;
    sel = $urandom_range(0, 99);
    if (sel < 35) begin
      // address set then a run of data-port accesses
      pick_vaddr(va);
      n = $urandom_range(1, 8);
      step = sh_ctrl[2] ? ppu_rmp_pkg::VA_STEP_WIDE : ppu_rmp_pkg::VA_STEP_ONE;
      if (va <= ppu_rmp_pkg::VA_PATTERN_END && $urandom_range(0, 3) != 0) begin
        for (int i = 0; i < n; i++) begin
          push_beat(ppu_rmp_pkg::OP_PAT_LOAD, 3'($urandom), 13'(va + i * step),
                    8'($urandom));
        end
      end
      if ($urandom_range(0, 4) != 0) begin
        push_beat(ppu_rmp_pkg::OP_REG_READ, ppu_rmp_pkg::REG_STATUS, 13'($urandom),
                  8'($urandom));
      end
      push_beat(ppu_rmp_pkg::OP_REG_WRITE, ppu_rmp_pkg::REG_VADDR, 13'($urandom), va[15:8]);
      push_beat(ppu_rmp_pkg::OP_REG_WRITE, ppu_rmp_pkg::REG_VADDR, 13'($urandom), va[7:0]);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 1)) begin
          push_beat(ppu_rmp_pkg::OP_REG_READ, ppu_rmp_pkg::REG_VDATA, 13'($urandom),
                    8'($urandom));
        end else begin
          push_beat(ppu_rmp_pkg::OP_REG_WRITE, ppu_rmp_pkg::REG_VDATA, 13'($urandom),
                    8'($urandom));
        end
      end
    end else if (sel < 45) begin
      push_beat(ppu_rmp_pkg::OP_REG_WRITE,
                $urandom_range(0, 1) ? ppu_rmp_pkg::REG_CTRL : ppu_rmp_pkg::REG_MASK,
                13'($urandom), 8'($urandom));
      push_beat(ppu_rmp_pkg::OP_REG_READ,
                3'($urandom_range(ppu_rmp_pkg::REG_CTRL, ppu_rmp_pkg::REG_MASK)),
                13'($urandom), 8'($urandom));
    end else if (sel < 55) begin
      push_beat(ppu_rmp_pkg::OP_VBL_BEGIN, 3'($urandom), 13'($urandom), 8'($urandom));
      n = $urandom_range(0, 2);
      for (int i = 0; i < n; i++) begin
        push_beat(ppu_rmp_pkg::OP_REG_READ, ppu_rmp_pkg::REG_STATUS, 13'($urandom),
                  8'($urandom));
      end
      if ($urandom_range(0, 1)) begin
        push_beat(ppu_rmp_pkg::OP_VBL_END, 3'($urandom), 13'($urandom), 8'($urandom));
      end
    end else if (sel < 65) begin
      push_beat(ppu_rmp_pkg::OP_REG_WRITE, ppu_rmp_pkg::REG_OAM_ADDR, 13'($urandom),
                8'($urandom));
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
        push_beat(ppu_rmp_pkg::OP_REG_WRITE, ppu_rmp_pkg::REG_OAM_DATA, 13'($urandom),
                  8'($urandom));
      end
      push_beat(ppu_rmp_pkg::OP_OAM_WRITE, 3'($urandom), 13'($urandom), 8'($urandom));
    end else if (sel < 75) begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
        push_beat(ppu_rmp_pkg::OP_PAT_LOAD, 3'($urandom), 13'($urandom), 8'($urandom));
      end
    end else if (sel < 80) begin
      push_beat(ppu_rmp_pkg::OP_REG_WRITE, ppu_rmp_pkg::REG_SCROLL, 13'($urandom),
                8'($urandom));
    end else begin
      push_beat(3'($urandom), 3'($urandom), 13'($urandom), 8'($urandom));
    end
  endtask

  // Idle gap length: mostly none, sometimes short, rarely long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 65) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic write_cfg(logic idx, logic val);
    @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk_i);
    cfg_we = 1'b0;
    if (idx == ppu_rmp_pkg::CFG_MIRROR_MODE) sh_mirror = val;
    else sh_pat_wr = val;
  endtask

  // Block is idle once every queued beat is in and every reply has come out
  task automatic wait_drained();
    while (cpu_beats_q.size() != 0 || in_valid || reply_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic note_mismatch(string what, logic [7:0] exp_v, logic [7:0] act_v);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("[%0t] mismatch on %s: expected %h, got %h", $time, what, exp_v, act_v);
  endtask

  // --------------------------------------------------------------------------
  // Driver: presents queued beats at the falling edge, holds each until taken
  // --------------------------------------------------------------------------
  int unsigned send_gap = 0;

  always @(negedge clk_i) begin : driver_p
    cpu_beat_t nb;
    if (in_valid && !in_taken) begin
      // beat still on offer, payload unchanged
    end else if (send_gap > 0) begin
      in_valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (cpu_beats_q.size() > 0) begin
      nb = cpu_beats_q.pop_front();
      in_valid     <= 1'b1;
      opcode       <= nb.op;
      reg_index    <= nb.idx;
      load_address <= nb.la;
      wdata        <= nb.d;
      send_gap     <= pick_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random ready gaps, plus one long hold-off on request so the
  // block backs up and stalls its input
  // --------------------------------------------------------------------------
  int unsigned stall_left = 0;

  always @(negedge clk_i) begin : receiver_p
    int unsigned g;
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      out_ready  <= 1'b0;
      stall_left <= HOLD_CYCLES - 1;
    end else begin
      g = pick_gap();
      out_ready  <= (g == 0);
      stall_left <= (g == 0) ? 0 : g - 1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: samples at the rising edge, checks each reply beat in order
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor_p
    cpu_reply_t exp_r;
    in_taken <= in_valid && (in_ready_o === 1'b1);
    if (rst_ni && out_valid_o === 1'b1 && out_ready) begin
      if (reply_q.size() == 0) begin
        note_mismatch("unexpected reply beat", 8'h00, read_data_o);
      end else begin
        exp_r = reply_q.pop_front();
        if (read_data_o !== exp_r.rdata) note_mismatch("read_data", exp_r.rdata, read_data_o);
        if (nmi_o !== exp_r.nmi) note_mismatch("nmi", 8'(exp_r.nmi), 8'(nmi_o));
      end
    end
  end

  // Watchdog: too long without any beat moving on either side
  always @(posedge clk_i) begin : watchdog_p
    if (rst_ni) begin
      if ((in_valid && in_ready_o === 1'b1) || (out_valid_o === 1'b1 && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus: reset, directed beats, then four random phases over all
  // mirror / pattern-write settings
  // --------------------------------------------------------------------------
  initial begin : stimulus_p
    int unsigned target;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_cfg(ppu_rmp_pkg::CFG_MIRROR_MODE, 1'b0);
    write_cfg(ppu_rmp_pkg::CFG_PATTERN_WRITABLE, 1'b0);

    // Directed: status read at reset, nmi on vblank, ignored status write,
    // OAM pointer wrap, scroll sharing the address latch, palette mirror,
    // unmapped reads with address wrap, zero replies for spare opcodes
    push_beat(ppu_rmp_pkg::OP_REG_READ,  ppu_rmp_pkg::REG_STATUS,   13'h0000, 8'h00);
    push_beat(ppu_rmp_pkg::OP_REG_WRITE, ppu_rmp_pkg::REG_CTRL,     13'h0000, 8'h84);
    push_beat(ppu_rmp_pkg::OP_VBL_BEGIN, ppu_rmp_pkg::REG_CTRL,     13'h0000, 8'h00);
    push_beat(ppu_rmp_pkg::OP_REG_WRITE, ppu_rmp_pkg::REG_MASK,     13'h1FFF, 8'hFF);
    push_beat(ppu_rmp_pkg::OP_REG_READ,  ppu_rmp_pkg::REG_MASK,     13'h0000, 8'h00);
    push_beat(ppu_rmp_pkg::OP_REG_WRITE, ppu_rmp_pkg::REG_STATUS,   13'h0000, 8'h00);
    push_beat(ppu_rmp_pkg::OP_REG_READ,  ppu_rmp_pkg::REG_STATUS,   13'h0000, 8'h00);
    push_beat(ppu_rmp_pkg::OP_REG_WRITE, ppu_rmp_pkg::REG_OAM_ADDR, 13'h0000, 8'hFF);
    push_beat(ppu_rmp_pkg::OP_REG_WRITE, ppu_rmp_pkg::REG_OAM_DATA, 13'h0000, 8'hAA);
    push_beat(ppu_rmp_pkg::OP_OAM_WRITE, ppu_rmp_pkg::REG_VDATA,    13'h1FFF, 8'h00);
    push_beat(ppu_rmp_pkg::OP_REG_WRITE, ppu_rmp_pkg::REG_SCROLL,   13'h0000, 8'h00);
    push_beat(ppu_rmp_pkg::OP_REG_WRITE, ppu_rmp_pkg::REG_VADDR,    13'h0000, 8'h3F);
    push_beat(ppu_rmp_pkg::OP_REG_WRITE, ppu_rmp_pkg::REG_VADDR,    13'h0000, 8'h3F);
    push_beat(ppu_rmp_pkg::OP_REG_WRITE, ppu_rmp_pkg::REG_VADDR,    13'h0000, 8'h00);
    push_beat(ppu_rmp_pkg::OP_REG_WRITE, ppu_rmp_pkg::REG_VDATA,    13'h0000, 8'h11);
    push_beat(ppu_rmp_pkg::OP_REG_WRITE, ppu_rmp_pkg::REG_VADDR,    13'h0000, 8'h3F);
    push_beat(ppu_rmp_pkg::OP_REG_WRITE, ppu_rmp_pkg::REG_VADDR,    13'h0000, 8'h10);
    push_beat(ppu_rmp_pkg::OP_REG_READ,  ppu_rmp_pkg::REG_VDATA,    13'h0000, 8'h00);
    push_beat(ppu_rmp_pkg::OP_PAT_LOAD,  ppu_rmp_pkg::REG_VDATA,    13'h1FFF, 8'hFF);
    push_beat(ppu_rmp_pkg::OP_REG_READ,  ppu_rmp_pkg::REG_VADDR,    13'h0000, 8'h00);
    push_beat(ppu_rmp_pkg::OP_REG_WRITE, ppu_rmp_pkg::REG_VADDR,    13'h0000, 8'hFF);
    push_beat(ppu_rmp_pkg::OP_REG_WRITE, ppu_rmp_pkg::REG_VADDR,    13'h0000, 8'hFF);
    push_beat(ppu_rmp_pkg::OP_REG_READ,  ppu_rmp_pkg::REG_VDATA,    13'h0000, 8'h00);
    push_beat(ppu_rmp_pkg::OP_VBL_END,   ppu_rmp_pkg::REG_CTRL,     13'h0000, 8'h00);
    push_beat(OP_SPARE_6,                ppu_rmp_pkg::REG_VDATA,    13'h1FFF, 8'hFF);
    push_beat(OP_SPARE_7,                ppu_rmp_pkg::REG_STATUS,   13'h0AAA, 8'h55);

    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      repeat (4) @(posedge clk_i);
      write_cfg(ppu_rmp_pkg::CFG_MIRROR_MODE, ph[0] ^ ph[1]);
      write_cfg(ppu_rmp_pkg::CFG_PATTERN_WRITABLE, ph[0]);
      gaps_on = (ph != 1);   // phase 1 runs back to back
      if (ph == 2) hold_req = 1'b1;
      target = beats_queued + PHASE_BEATS;
      while (beats_queued < target) random_burst();
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/ppu_rmp_pkg.sv
hw/rtl/ppu_register_memory_port.sv
hw/rtl/ppu_rmp_checker.sv
test/ppu_register_memory_port_tb.sv
